>>> sv/swam_pkg.sv
// Shared types, constants and arithmetic helpers for the shifted-window mask core.
`timescale 1ns / 1ps

package swam_pkg;

	localparam int GRID_W      = 9;
	localparam int WIN_W       = 5;
	localparam int SHIFT_W     = 4;
	localparam int RECIP_W     = 14;
	localparam int RECIP_SHIFT = 13;
	localparam int CFG_DATA_W  = 9;
	localparam int NWIN_W      = 18;
	localparam int REM_W       = 17;

	localparam logic [GRID_W-1:0] MAX_GRID   = 9'd256;
	localparam logic [WIN_W-1:0]  MAX_WINDOW = 5'd16;

	localparam logic [31:0] MASK_NEG_BITS  = 32'hC2C8_0000;
	localparam logic [31:0] MASK_ZERO_BITS = 32'h0000_0000;

	// Cycles of derived-setting update after reset or a register write
	localparam logic [1:0] CFG_SETTLE = 2'd3;

	typedef enum logic [1:0] {
		REG_GRID_ROWS,
		REG_GRID_COLS,
		REG_WINDOW_SIZE,
		REG_SHIFT_SIZE
	} swam_reg_t;

	// Settings as the datapath sees them, already clamped and pre-digested
	typedef struct packed {
		logic [GRID_W-1:0]  h;
		logic [GRID_W-1:0]  w;
		logic [WIN_W-1:0]   ws;
		logic [RECIP_W-1:0] m_ws;
		logic [SHIFT_W-1:0] sh_h;
		logic [SHIFT_W-1:0] sh_w;
		logic [GRID_W-1:0]  wtok;
		logic [GRID_W-1:0]  nww;
		logic [NWIN_W-1:0]  nwin;
	} swam_cfg_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic             qbit;
	} swam_dstep_t;

	// ceil(2^13 / ws); exact quotient for dividends below 512
	function automatic logic [RECIP_W-1:0] recip_of(input logic [WIN_W-1:0] ws);
		logic [RECIP_W-1:0] r;
		begin
			case (ws)
				5'd2:    r = 14'd4096;
				5'd3:    r = 14'd2731;
				5'd4:    r = 14'd2048;
				5'd5:    r = 14'd1639;
				5'd6:    r = 14'd1366;
				5'd7:    r = 14'd1171;
				5'd8:    r = 14'd1024;
				5'd9:    r = 14'd911;
				5'd10:   r = 14'd820;
				5'd11:   r = 14'd745;
				5'd12:   r = 14'd683;
				5'd13:   r = 14'd631;
				5'd14:   r = 14'd586;
				5'd15:   r = 14'd547;
				5'd16:   r = 14'd512;
				default: r = 14'd8192;
			endcase
			return r;
		end
	endfunction

	// x / ws through the reciprocal
	function automatic logic [GRID_W-1:0] div_ws(input logic [GRID_W-1:0] x,
			input logic [RECIP_W-1:0] m);
		logic [GRID_W+RECIP_W-1:0] p;
		begin
			p = {{(GRID_W){1'b0}}, x} * {{(GRID_W){1'b0}}, m};
			return p[RECIP_SHIFT+GRID_W-1:RECIP_SHIFT];
		end
	endfunction

	// One restoring-division step at quotient bit position sh
	function automatic swam_dstep_t div_step(input logic [REM_W-1:0] rem,
			input logic [GRID_W-1:0] d, input int sh);
		logic [REM_W-1:0] sub;
		swam_dstep_t      r;
		begin
			sub = {{(REM_W-GRID_W){1'b0}}, d} << sh;
			if (rem >= sub) begin
				r.rem  = rem - sub;
				r.qbit = 1'b1;
			end else begin
				r.rem  = rem;
				r.qbit = 1'b0;
			end
			return r;
		end
	endfunction

	// sh mod n for a 4-bit shift, four conditional subtracts
	function automatic logic [SHIFT_W-1:0] shift_mod(input logic [SHIFT_W-1:0] sh,
			input logic [GRID_W-1:0] n);
		logic [GRID_W+2:0] r;
		logic [GRID_W+2:0] sub;
		begin
			r = {{(GRID_W-1){1'b0}}, sh};
			for (int i = 3; i >= 0; i--) begin
				sub = {3'b000, n} << i;
				if (r >= sub)
					r = r - sub;
			end
			return r[SHIFT_W-1:0];
		end
	endfunction

	// (a + s) mod n, for a < n and s < n
	function automatic logic [GRID_W-1:0] wrap_add(input logic [GRID_W-1:0] a,
			input logic [SHIFT_W-1:0] s, input logic [GRID_W-1:0] n);
		logic [GRID_W:0] t;
		begin
			t = {1'b0, a} + {{(GRID_W-SHIFT_W+1){1'b0}}, s};
			if (t >= {1'b0, n})
				t = t - {1'b0, n};
			return t[GRID_W-1:0];
		end
	endfunction

endpackage

>>> sv/swam_if.sv
// Handshake interfaces for the config, pair and mask channels.
`timescale 1ns / 1ps

interface swam_cfg_if;
	import swam_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [1:0]            index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface swam_pair_if;
	logic        valid;
	logic        ready;
	logic [15:0] window_index;
	logic [7:0]  query_token;
	logic [7:0]  key_token;

	modport source (output valid, window_index, query_token, key_token, input ready);
	modport sink (input valid, window_index, query_token, key_token, output ready);
endinterface

interface swam_mask_if;
	logic        valid;
	logic        ready;
	logic        masked;
	logic [31:0] mask_bits;

	modport source (output valid, masked, mask_bits, input ready);
	modport sink (input valid, masked, mask_bits, output ready);
endinterface

>>> sv/shifted_window_attention_mask_core.sv
// Top level: eight-stage pipeline producing one shifted-window mask entry per item.
`timescale 1ns / 1ps

//  channel | role   | payload                                  | handshake
//  cfg     | sink   | index[1:0], data[8:0]                    | valid/ready
//  pair    | sink   | window_index, query_token, key_token     | valid/ready
//  mask    | source | masked, mask_bits[31:0]                  | valid/ready
//
// One item per cycle unless mask holds the output or settings update; an item passes
// through stage registers s1 to s8 to the output register. The four-stage restoring
// divider splits the window index into window row and column. After reset and after
// every register write, pair.ready stays low while derived settings update.
// A stall on mask freezes all stages together; nothing is dropped or repeated.

module shifted_window_attention_mask_core
	import swam_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	swam_cfg_if.sink   cfg,
	swam_pair_if.sink  pair,
	swam_mask_if.source mask
);

	swam_cfg_t settings;
	logic      cfg_busy;
	logic      en;

	swam_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.settings (settings),
		.busy     (cfg_busy)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [15:0]       win_s1;
	logic [7:0]        q_s1, k_s1;

	logic [7:0]        q_s2, k_s2, qr_s2, kr_s2;
	logic              ok_s2;
	logic [REM_W-1:0]  rem_s2;
	logic [7:0]        quo_s2;

	logic [7:0]        qr_s3, kr_s3, qc_s3, kc_s3;
	logic              ok_s3;
	logic [REM_W-1:0]  rem_s3;
	logic [7:0]        quo_s3;

	logic [7:0]        qr_s4, kr_s4, qc_s4, kc_s4;
	logic              ok_s4;
	logic [REM_W-1:0]  rem_s4;
	logic [7:0]        quo_s4;

	logic [7:0]        qr_s5, kr_s5, qc_s5, kc_s5;
	logic              ok_s5;
	logic [7:0]        wy_s5, wx_s5;

	logic [GRID_W-1:0] qya_s6, qxa_s6, kya_s6, kxa_s6;
	logic              ok_s6;

	logic [GRID_W-1:0] qy_s7, qx_s7, ky_s7, kx_s7;
	logic              ok_s7;

	logic              masked_s8;

	// whole pipe advances unless the output register is held
	assign en         = !v_s8 || mask.ready;
	assign pair.ready = en && !cfg_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid && !cfg_busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: input capture
	always_ff @(posedge clk) begin
		if (en) begin
			win_s1 <= pair.window_index;
			q_s1   <= pair.query_token;
			k_s1   <= pair.key_token;
		end
	end

	// stage 2: token rows, range check, divider bits 7..6
	logic [GRID_W-1:0] qr1, kr1;
	logic              ok1;
	swam_dstep_t       d7, d6;

	always_comb begin
		qr1 = div_ws({1'b0, q_s1}, settings.m_ws);
		kr1 = div_ws({1'b0, k_s1}, settings.m_ws);
		ok1 = ({{(NWIN_W-16){1'b0}}, win_s1} < settings.nwin)
			&& ({1'b0, q_s1} < settings.wtok) && ({1'b0, k_s1} < settings.wtok);
		d7  = div_step({1'b0, win_s1}, settings.nww, 7);
		d6  = div_step(d7.rem, settings.nww, 6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2   <= q_s1;
			k_s2   <= k_s1;
			qr_s2  <= qr1[7:0];
			kr_s2  <= kr1[7:0];
			ok_s2  <= ok1;
			rem_s2 <= d6.rem;
			quo_s2 <= {d7.qbit, d6.qbit, 6'b000000};
		end
	end

	// stage 3: token columns, divider bits 5..4
	logic [GRID_W+WIN_W-1:0] qrp, krp;
	swam_dstep_t             d5, d4;

	always_comb begin
		qrp = {1'b0, qr_s2} * settings.ws;
		krp = {1'b0, kr_s2} * settings.ws;
		d5  = div_step(rem_s2, settings.nww, 5);
		d4  = div_step(d5.rem, settings.nww, 4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s3  <= qr_s2;
			kr_s3  <= kr_s2;
			qc_s3  <= q_s2 - qrp[7:0];
			kc_s3  <= k_s2 - krp[7:0];
			ok_s3  <= ok_s2;
			rem_s3 <= d4.rem;
			quo_s3 <= {quo_s2[7:6], d5.qbit, d4.qbit, 4'b0000};
		end
	end

	// stage 4: divider bits 3..2
	swam_dstep_t d3, d2;

	always_comb begin
		d3 = div_step(rem_s3, settings.nww, 3);
		d2 = div_step(d3.rem, settings.nww, 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s4  <= qr_s3;
			kr_s4  <= kr_s3;
			qc_s4  <= qc_s3;
			kc_s4  <= kc_s3;
			ok_s4  <= ok_s3;
			rem_s4 <= d2.rem;
			quo_s4 <= {quo_s3[7:4], d3.qbit, d2.qbit, 2'b00};
		end
	end

	// stage 5: divider bits 1..0 give window row and column
	swam_dstep_t d1, d0;

	always_comb begin
		d1 = div_step(rem_s4, settings.nww, 1);
		d0 = div_step(d1.rem, settings.nww, 0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s5 <= qr_s4;
			kr_s5 <= kr_s4;
			qc_s5 <= qc_s4;
			kc_s5 <= kc_s4;
			ok_s5 <= ok_s4;
			wy_s5 <= {quo_s4[7:2], d1.qbit, d0.qbit};
			wx_s5 <= d0.rem[7:0];
		end
	end

	// stage 6: absolute grid positions before the shift
	logic [GRID_W+WIN_W-1:0] by5, bx5;

	always_comb begin
		by5 = {1'b0, wy_s5} * settings.ws;
		bx5 = {1'b0, wx_s5} * settings.ws;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qya_s6 <= by5[GRID_W-1:0] + {1'b0, qr_s5};
			kya_s6 <= by5[GRID_W-1:0] + {1'b0, kr_s5};
			qxa_s6 <= bx5[GRID_W-1:0] + {1'b0, qc_s5};
			kxa_s6 <= bx5[GRID_W-1:0] + {1'b0, kc_s5};
			ok_s6  <= ok_s5;
		end
	end

	// stage 7: cyclic shift with wrap at the grid edge
	always_ff @(posedge clk) begin
		if (en) begin
			qy_s7 <= wrap_add(qya_s6, settings.sh_h, settings.h);
			ky_s7 <= wrap_add(kya_s6, settings.sh_h, settings.h);
			qx_s7 <= wrap_add(qxa_s6, settings.sh_w, settings.w);
			kx_s7 <= wrap_add(kxa_s6, settings.sh_w, settings.w);
			ok_s7 <= ok_s6;
		end
	end

	// stage 8: compare region labels into the output register
	logic diff7;

	always_comb begin
		diff7 = (div_ws(qy_s7, settings.m_ws) != div_ws(ky_s7, settings.m_ws))
			|| (div_ws(qx_s7, settings.m_ws) != div_ws(kx_s7, settings.m_ws));
	end

	always_ff @(posedge clk) begin
		if (en)
			masked_s8 <= ok_s7 && diff7;
	end

	assign mask.valid     = v_s8;
	assign mask.masked    = masked_s8;
	assign mask.mask_bits = masked_s8 ? MASK_NEG_BITS : MASK_ZERO_BITS;

endmodule

>>> sv/swam_cfg.sv
// Configuration registers and the settings derived from them.
`timescale 1ns / 1ps

module swam_cfg
	import swam_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	swam_cfg_if.sink     cfg,
	output swam_cfg_t    settings,
	output logic         busy
);

	logic [GRID_W-1:0]  rows_q, cols_q;
	logic [WIN_W-1:0]   win_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [1:0]         settle_q;

	// first derived level: clamped sizes and reciprocal
	logic [GRID_W-1:0]  h_q, w_q;
	logic [WIN_W-1:0]   ws_q;
	logic [RECIP_W-1:0] m_q;
	logic [SHIFT_W-1:0] sh_q;
	// second level: window grid, wrapped shifts, tokens per window
	logic [GRID_W-1:0]  nwh_q, nww_q, wtok_q;
	logic [SHIFT_W-1:0] sh_h_q, sh_w_q;
	// third level: window count
	logic [NWIN_W-1:0]  nwin_q;

	logic [GRID_W-1:0]  h_c, w_c;
	logic [WIN_W-1:0]   ws_c;
	logic [2*WIN_W-1:0] wtok_p;

	assign cfg.ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= 9'd8;
			cols_q  <= 9'd8;
			win_q   <= 5'd4;
			shift_q <= 4'd2;
		end else if (cfg.valid) begin
			unique case (swam_reg_t'(cfg.index))
				REG_GRID_ROWS:   rows_q  <= cfg.data;
				REG_GRID_COLS:   cols_q  <= cfg.data;
				REG_WINDOW_SIZE: win_q   <= cfg.data[WIN_W-1:0];
				REG_SHIFT_SIZE:  shift_q <= cfg.data[SHIFT_W-1:0];
			endcase
		end
	end

	// hold off items until the derived chain has caught up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			settle_q <= CFG_SETTLE;
		else if (cfg.valid)
			settle_q <= CFG_SETTLE;
		else if (settle_q != 2'd0)
			settle_q <= settle_q - 2'd1;
	end

	assign busy = (settle_q != 2'd0);

	// clamp to the supported ranges
	always_comb begin
		h_c  = (rows_q == '0) ? 9'd1 : ((rows_q > MAX_GRID) ? MAX_GRID : rows_q);
		w_c  = (cols_q == '0) ? 9'd1 : ((cols_q > MAX_GRID) ? MAX_GRID : cols_q);
		ws_c = (win_q == '0) ? 5'd1 : ((win_q > MAX_WINDOW) ? MAX_WINDOW : win_q);
	end

	assign wtok_p = ws_q * ws_q;

	// derived chain, one level per cycle
	always_ff @(posedge clk) begin
		h_q    <= h_c;
		w_q    <= w_c;
		ws_q   <= ws_c;
		m_q    <= recip_of(ws_c);
		sh_q   <= shift_q;
		nwh_q  <= div_ws(h_q, m_q);
		nww_q  <= div_ws(w_q, m_q);
		wtok_q <= wtok_p[GRID_W-1:0];
		sh_h_q <= shift_mod(sh_q, h_q);
		sh_w_q <= shift_mod(sh_q, w_q);
		nwin_q <= nwh_q * nww_q;
	end

	always_comb begin
		settings.h    = h_q;
		settings.w    = w_q;
		settings.ws   = ws_q;
		settings.m_ws = m_q;
		settings.sh_h = sh_h_q;
		settings.sh_w = sh_w_q;
		settings.wtok = wtok_q;
		settings.nww  = nww_q;
		settings.nwin = nwin_q;
	end

endmodule

>>> tb/sv/swam_mask_checker.sv
// Checker for the mask core: tracks register writes, predicts each mask entry, compares results.
`timescale 1ns / 1ps

module swam_mask_checker
	import swam_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	swam_cfg_if  cfg,
	swam_pair_if pair,
	swam_mask_if mask,
	output int   fail_count,
	output int   outstanding
);

	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic        masked;
		logic [31:0] bits;
	} mask_entry_t;

	// Shadow copy of the registers as written
	logic [GRID_W-1:0]  rows_r  = 9'd8;
	logic [GRID_W-1:0]  cols_r  = 9'd8;
	logic [WIN_W-1:0]   win_r   = 5'd4;
	logic [SHIFT_W-1:0] shift_r = 4'd2;

	mask_entry_t mask_expect_q [$];
	int          fails     = 0;
	int          pending_n = 0;

	assign fail_count  = fails;
	assign outstanding = pending_n;

	// Region compare of the shifted query and key positions
	function automatic mask_entry_t predict_entry(input logic [15:0] window,
			input logic [7:0] query, input logic [7:0] key);
		int unsigned h, w, ws, sh, nwh, nww, wtok, wy, wx, qy, qx, ky, kx;
		mask_entry_t e;
		h  = (rows_r == 0) ? 1 : (rows_r > MAX_GRID) ? MAX_GRID : rows_r;
		w  = (cols_r == 0) ? 1 : (cols_r > MAX_GRID) ? MAX_GRID : cols_r;
		ws = (win_r == 0) ? 1 : (win_r > MAX_WINDOW) ? MAX_WINDOW : win_r;
		sh = shift_r;
		nwh  = h / ws;
		nww  = w / ws;
		wtok = ws * ws;
		e.masked = 1'b0;
		e.bits   = MASK_ZERO_BITS;
		// out-of-range window or token gives an unmasked zero
		if (nww == 0 || window >= nwh * nww || query >= wtok || key >= wtok)
			return e;
		wy = window / nww;
		wx = window % nww;
		qy = (wy * ws + query / ws + sh) % h;
		qx = (wx * ws + query % ws + sh) % w;
		ky = (wy * ws + key / ws + sh) % h;
		kx = (wx * ws + key % ws + sh) % w;
		if (qy / ws != ky / ws || qx / ws != kx / ws) begin
			e.masked = 1'b1;
			e.bits   = MASK_NEG_BITS;
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mask_entry_t got, want;
		if (!arst_n) begin
			rows_r    <= 9'd8;
			cols_r    <= 9'd8;
			win_r     <= 5'd4;
			shift_r   <= 4'd2;
			pending_n <= 0;
			mask_expect_q.delete();
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (swam_reg_t'(cfg.index))
					REG_GRID_ROWS:   rows_r  <= cfg.data;
					REG_GRID_COLS:   cols_r  <= cfg.data;
					REG_WINDOW_SIZE: win_r   <= cfg.data[WIN_W-1:0];
					REG_SHIFT_SIZE:  shift_r <= cfg.data[SHIFT_W-1:0];
					default: ;
				endcase
			end
			// one expected entry per accepted pair item
			if (pair.valid && pair.ready)
				mask_expect_q.push_back(predict_entry(pair.window_index, pair.query_token,
					pair.key_token));
			// compare each accepted mask item with the oldest expectation
			if (mask.valid && mask.ready) begin
				got.masked = mask.masked;
				got.bits   = mask.mask_bits;
				if (mask_expect_q.size() == 0) begin
					if (fails < MAX_REPORTS)
						$display("%0t: unexpected mask item, got masked=%0b bits=%h",
							$time, got.masked, got.bits);
					fails++;
				end else begin
					want = mask_expect_q.pop_front();
					if (got.masked !== want.masked || got.bits !== want.bits) begin
						if (fails < MAX_REPORTS)
							$display("%0t: mask mismatch, expected masked=%0b bits=%h, got masked=%0b bits=%h",
								$time, want.masked, want.bits, got.masked, got.bits);
						fails++;
					end
				end
			end
			pending_n <= mask_expect_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Testbench top: clock, reset, stimulus, output stalls and verdict for the mask core.
`timescale 1ns / 1ps

module testbench;
	import swam_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int N_PHASES        = 12;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int LONG_STALL      = 64;
	localparam int BURST_ITEMS     = 40;
	localparam int DRAIN_CYCLES    = 20;
	localparam int TIMEOUT_NS      = 2_000_000;

	typedef struct packed {
		logic [GRID_W-1:0]  rows;
		logic [GRID_W-1:0]  cols;
		logic [WIN_W-1:0]   ws;
		logic [SHIFT_W-1:0] sh;
	} setting_t;

	// {window_index, query_token, key_token} at the reset settings (8x8 grid, 4x4 windows)
	localparam logic [31:0] DIRECTED [18] = '{
		{16'd0, 8'd0, 8'd0},
		{16'd0, 8'd0, 8'd15},
		{16'd0, 8'd15, 8'd15},
		{16'd0, 8'd5, 8'd10},
		{16'd1, 8'd0, 8'd15},
		{16'd1, 8'd15, 8'd15},
		{16'd2, 8'd3, 8'd12},
		{16'd3, 8'd0, 8'd15},
		{16'd3, 8'd15, 8'd0},
		{16'd3, 8'd10, 8'd10},
		{16'd3, 8'd6, 8'd9},
		{16'd4, 8'd0, 8'd0},
		{16'd65535, 8'd0, 8'd0},
		{16'd0, 8'd16, 8'd0},
		{16'd0, 8'd0, 8'd16},
		{16'd0, 8'd255, 8'd255},
		{16'd65535, 8'd255, 8'd255},
		{16'd2, 8'd255, 8'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   outstanding;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic stall_go       = 1'b0;
	logic stall_seen     = 1'b0;
	int   stall_left     = 0;
	int   items_sent     = 0;

	int unsigned cur_nwin = 4;
	int unsigned cur_wtok = 16;

	swam_cfg_if  cfg_bus ();
	swam_pair_if pair_bus ();
	swam_mask_if mask_bus ();

	shifted_window_attention_mask_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.pair   (pair_bus),
		.mask   (mask_bus)
	);

	swam_mask_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_bus),
		.pair        (pair_bus),
		.mask        (mask_bus),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #CLK_HALF clk = ~clk;

	// Output side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_left > 0) begin
			mask_bus.ready <= 1'b0;
			stall_left     <= stall_left - 1;
		end else if (stall_go != stall_seen) begin
			mask_bus.ready <= 1'b0;
			stall_seen     <= stall_go;
			stall_left     <= LONG_STALL - 1;
		end else begin
			mask_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic setting_t phase_setting(input int p);
		case (p)
			1:       return '{9'd256, 9'd256, 5'd16, 4'd15};
			2:       return '{9'd0, 9'd0, 5'd0, 4'd0};
			3:       return '{9'd511, 9'd511, 5'd31, 4'd15};
			4:       return '{9'd256, 9'd256, 5'd1, 4'd0};
			5:       return '{9'd1, 9'd1, 5'd1, 4'd15};
			6:       return '{9'd30, 9'd50, 5'd7, 4'd3};
			7:       return '{9'd16, 9'd48, 5'd8, 4'd4};
			8:       return '{9'd100, 9'd37, 5'd5, 4'd15};
			9:       return '{9'd255, 9'd17, 5'd16, 4'd9};
			10:      return '{9'd12, 9'd40, 5'd16, 4'd5};
			11:      return '{9'd64, 9'd64, 5'd2, 4'd1};
			default: return '{9'd8, 9'd8, 5'd4, 4'd2};
		endcase
	endfunction

	// Window count and tokens per window, so random items land mostly in range
	task automatic set_bounds(input setting_t s);
		int unsigned h, w, ws;
		h  = (s.rows == 0) ? 1 : (s.rows > MAX_GRID) ? MAX_GRID : s.rows;
		w  = (s.cols == 0) ? 1 : (s.cols > MAX_GRID) ? MAX_GRID : s.cols;
		ws = (s.ws == 0) ? 1 : (s.ws > MAX_WINDOW) ? MAX_WINDOW : s.ws;
		cur_nwin = (h / ws) * (w / ws);
		cur_wtok = ws * ws;
	endtask

	task automatic send_pair(input logic [15:0] window, input logic [7:0] query,
			input logic [7:0] key);
		pair_bus.valid        <= 1'b1;
		pair_bus.window_index <= window;
		pair_bus.query_token  <= query;
		pair_bus.key_token    <= key;
		do @(posedge clk); while (!pair_bus.ready);
		items_sent++;
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			pair_bus.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Mostly in-range items, some just past the edges, some fully random
	task automatic send_random();
		int unsigned pick;
		logic [15:0] window;
		logic [7:0]  query, key;
		pick = $urandom_range(99);
		if (cur_nwin == 0 || pick < 12) begin
			window = 16'($urandom);
			query  = 8'($urandom);
			key    = 8'($urandom);
		end else if (pick < 20) begin
			window = 16'(cur_nwin - 1 + $urandom_range(1));
			query  = 8'(cur_wtok - 1 + $urandom_range(1));
			key    = 8'(cur_wtok - 1 + $urandom_range(1));
		end else begin
			window = 16'($urandom_range(cur_nwin - 1));
			query  = 8'($urandom_range(cur_wtok - 1));
			key    = 8'($urandom_range(cur_wtok - 1));
		end
		send_pair(window, query, key);
	endtask

	// Stop offering and wait until every expected result has come
	task automatic drain_results();
		pair_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_settings(input setting_t s);
		logic [CFG_DATA_W-1:0] vals [4];
		vals[0] = s.rows;
		vals[1] = s.cols;
		vals[2] = CFG_DATA_W'(s.ws);
		vals[3] = CFG_DATA_W'(s.sh);
		for (int i = 0; i < 4; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= swam_reg_t'(i);
			cfg_bus.data  <= vals[i];
			do @(posedge clk); while (!cfg_bus.ready);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		setting_t    s;
		logic [31:0] d;
		int          burst;
		burst                 = 0;
		arst_n                = 1'b0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = REG_GRID_ROWS;
		cfg_bus.data          = '0;
		pair_bus.valid        = 1'b0;
		pair_bus.window_index = '0;
		pair_bus.query_token  = '0;
		pair_bus.key_token    = '0;
		mask_bus.ready        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed items at the reset settings
		foreach (DIRECTED[i]) begin
			d = DIRECTED[i];
			send_pair(d[31:16], d[15:8], d[7:0]);
		end

		// random phases, one register setting each
		for (int p = 0; p < N_PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				s = phase_setting(p);
				write_settings(s);
				set_bounds(s);
			end
			case (p % 4)
				0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1:       begin send_idle_pct = 70; recv_stall_pct <= 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct <= 70; end
				default: begin send_idle_pct = 27; recv_stall_pct <= 27; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2 && p % 2 == 1)
					drain_results();
				// long output hold-off while items keep coming back to back
				if (i == 10 && p % 3 == 0) begin
					stall_go <= ~stall_go;
					burst = BURST_ITEMS;
				end
				if (burst > 0)
					burst--;
				else
					sender_gap();
				send_random();
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items over %0d register settings: clamped sizes, partial tiles,",
			items_sent, N_PHASES);
		$display("shifts past the window, out-of-range indexes, idle/stall mixes and a long hold-off.");
		if (fail_count == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout: mask results stopped arriving");
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
sv/swam_pkg.sv
sv/swam_if.sv
sv/swam_cfg.sv
sv/shifted_window_attention_mask_core.sv
tb/sv/swam_mask_checker.sv
tb/sv/testbench.sv
